// ----- src/hsv_threshold_tile_counter_assert.svh -----
// ----------------------------------------------------------------------------
// hsv threshold tile counter assertion macros
// Shorthand for the concurrent checks of the tile counter, clocked on clk_i
// and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HSV_THRESHOLD_TILE_COUNTER_ASSERT_SVH
`define HSV_THRESHOLD_TILE_COUNTER_ASSERT_SVH

// expression must never be true
`define HTC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

// antecedent implies consequent sequence
`define HTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) else $error(msg);

`endif

// ----- src/htc_pkg.sv -----
// ----------------------------------------------------------------------------
// htc_pkg
// Constants, register codes and shared types of the hsv threshold tile counter.
// ----------------------------------------------------------------------------
package htc_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int TILE_SIZE  = 16;
  localparam int ROW_LIMIT  = 2048;
  localparam int TILE_SLOTS = MAX_WIDTH / TILE_SIZE;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int THR_W      = 9;
  localparam int DIM_W      = 12;
  localparam int TILE_IDX_W = 7;
  localparam int WCOUNT_W   = 9;
  localparam int WCOUNT_MAX = 511;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // derived widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(ROW_LIMIT);
  localparam int EXT_W  = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
  localparam int SUB_W  = $clog2(TILE_SIZE);
  localparam int TCOL_W = $clog2(TILE_SLOTS);
  localparam int TROW_W = $clog2(ROW_LIMIT / TILE_SIZE);
  localparam int CNT_W  = $clog2(TILE_SIZE * TILE_SIZE + 1);
  localparam int CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;

  // pixel queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // register reset values
  localparam logic [PIX_W-1:0] HUE_LOW_RST   = PIX_W'(20);
  localparam logic [PIX_W-1:0] HUE_HIGH_RST  = PIX_W'(120);
  localparam logic [PIX_W-1:0] SAT_MIN_RST   = PIX_W'(25);
  localparam logic [PIX_W-1:0] VAL_MIN_RST   = PIX_W'(10);
  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(256);
  localparam logic [DIM_W-1:0] WIDTH_RST     = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST    = DIM_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUE_LOW      = 3'd0,
    CFG_HUE_HIGH     = 3'd1,
    CFG_SAT_MIN      = 3'd2,
    CFG_VAL_MIN      = 3'd3,
    CFG_THRESHOLD    = 3'd4,
    CFG_IMAGE_WIDTH  = 3'd5,
    CFG_IMAGE_HEIGHT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] hue_low;
    logic [PIX_W-1:0] hue_high;
    logic [PIX_W-1:0] sat_min;
    logic [PIX_W-1:0] val_min;
    logic [THR_W-1:0] count_threshold;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic              white;
    logic              counted;
    logic              tile_first;
    logic              tile_last;
    logic [TCOL_W-1:0] tcol;
    logic [TROW_W-1:0] trow;
  } pix_item_t;

  typedef struct packed {
    logic                  is_white;
    logic                  seed_valid;
    logic [TILE_IDX_W-1:0] tile_row;
    logic [TILE_IDX_W-1:0] tile_col;
    logic [WCOUNT_W-1:0]   white_count;
  } result_t;

endpackage

// ----- src/htc_ram.sv -----
// ----------------------------------------------------------------------------
// htc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module htc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read during write returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/htc_front.sv -----
// ----------------------------------------------------------------------------
// htc_front
// Binarizes each pixel, tracks the raster position and tags tile membership.
// ----------------------------------------------------------------------------
module htc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [htc_pkg::PIX_W-1:0] hue_i,
  input  logic [htc_pkg::PIX_W-1:0] saturation_i,
  input  logic [htc_pkg::PIX_W-1:0] brightness_i,
  input  logic                     frame_start_i,
  input  htc_pkg::cfg_t            cfg_i,
  input  logic                     q_full_i,
  output logic                     q_wr_o,
  output htc_pkg::pix_item_t       q_item_o
);

  logic [htc_pkg::COL_W-1:0]  col_q, col_d, cur_col;
  logic [htc_pkg::SUB_W-1:0]  sx_q, sx_d, cur_sx;
  logic [htc_pkg::TCOL_W-1:0] tc_q, tc_d, cur_tc;
  logic [htc_pkg::ROW_W-1:0]  row_q, row_d, cur_row;
  logic [htc_pkg::SUB_W-1:0]  sy_q, sy_d, cur_sy;
  logic [htc_pkg::TROW_W-1:0] tr_q, tr_d, cur_tr;

  logic [htc_pkg::EXT_W-1:0] w_eff, tiles_x, col_inc;
  logic [htc_pkg::DIM_W-1:0] h_eff, tiles_y, row_inc;
  logic                      white, accept;

  assign accept = push_i && !q_full_i;
  assign q_wr_o = accept;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      w_eff = htc_pkg::EXT_W'(1);
    end else if (htc_pkg::EXT_W'(cfg_i.image_width) > htc_pkg::EXT_W'(htc_pkg::MAX_WIDTH)) begin
      w_eff = htc_pkg::EXT_W'(htc_pkg::MAX_WIDTH);
    end else begin
      w_eff = htc_pkg::EXT_W'(cfg_i.image_width);
    end
    if (cfg_i.image_height == '0) begin
      h_eff = htc_pkg::DIM_W'(1);
    end else if (cfg_i.image_height > htc_pkg::DIM_W'(htc_pkg::ROW_LIMIT)) begin
      h_eff = htc_pkg::DIM_W'(htc_pkg::ROW_LIMIT);
    end else begin
      h_eff = cfg_i.image_height;
    end
  end

  assign tiles_x = htc_pkg::EXT_W'(w_eff / htc_pkg::TILE_SIZE);
  assign tiles_y = htc_pkg::DIM_W'(h_eff / htc_pkg::TILE_SIZE);

  // frame start puts this pixel at the origin
  assign cur_col = frame_start_i ? '0 : col_q;
  assign cur_sx  = frame_start_i ? '0 : sx_q;
  assign cur_tc  = frame_start_i ? '0 : tc_q;
  assign cur_row = frame_start_i ? '0 : row_q;
  assign cur_sy  = frame_start_i ? '0 : sy_q;
  assign cur_tr  = frame_start_i ? '0 : tr_q;

  assign white = (hue_i < cfg_i.hue_low || hue_i > cfg_i.hue_high) &&
                 saturation_i >= cfg_i.sat_min && brightness_i >= cfg_i.val_min;

  always_comb begin
    q_item_o.white      = white;
    q_item_o.counted    = (htc_pkg::EXT_W'(cur_tc) < tiles_x) &&
                          (htc_pkg::DIM_W'(cur_tr) < tiles_y);
    q_item_o.tile_first = (cur_sx == '0) && (cur_sy == '0);
    q_item_o.tile_last  = (cur_sx == htc_pkg::SUB_W'(htc_pkg::TILE_SIZE - 1)) &&
                          (cur_sy == htc_pkg::SUB_W'(htc_pkg::TILE_SIZE - 1));
    q_item_o.tcol       = cur_tc;
    q_item_o.trow       = cur_tr;
  end

  // position step with wrap at the current geometry
  always_comb begin
    col_inc = htc_pkg::EXT_W'(cur_col) + htc_pkg::EXT_W'(1);
    row_inc = htc_pkg::DIM_W'(cur_row) + htc_pkg::DIM_W'(1);
    col_d   = cur_col;
    sx_d    = cur_sx;
    tc_d    = cur_tc;
    row_d   = cur_row;
    sy_d    = cur_sy;
    tr_d    = cur_tr;
    if (col_inc >= w_eff) begin
      col_d = '0;
      sx_d  = '0;
      tc_d  = '0;
      if (row_inc >= h_eff) begin
        row_d = '0;
        sy_d  = '0;
        tr_d  = '0;
      end else begin
        row_d = htc_pkg::ROW_W'(row_inc);
        if (cur_sy == htc_pkg::SUB_W'(htc_pkg::TILE_SIZE - 1)) begin
          sy_d = '0;
          tr_d = cur_tr + htc_pkg::TROW_W'(1);
        end else begin
          sy_d = cur_sy + htc_pkg::SUB_W'(1);
        end
      end
    end else begin
      col_d = htc_pkg::COL_W'(col_inc);
      if (cur_sx == htc_pkg::SUB_W'(htc_pkg::TILE_SIZE - 1)) begin
        sx_d = '0;
        tc_d = cur_tc + htc_pkg::TCOL_W'(1);
      end else begin
        sx_d = cur_sx + htc_pkg::SUB_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      sx_q  <= '0;
      tc_q  <= '0;
      row_q <= '0;
      sy_q  <= '0;
      tr_q  <= '0;
    end else if (accept) begin
      col_q <= col_d;
      sx_q  <= sx_d;
      tc_q  <= tc_d;
      row_q <= row_d;
      sy_q  <= sy_d;
      tr_q  <= tr_d;
    end
  end

endmodule

// ----- src/htc_queue.sv -----
// ----------------------------------------------------------------------------
// htc_queue
// Short FIFO of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module htc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  htc_pkg::pix_item_t wr_item_i,
  output logic               full_o,
  input  logic               rd_en_i,
  output htc_pkg::pix_item_t rd_item_o,
  output logic               empty_o
);

  htc_pkg::pix_item_t mem_q [htc_pkg::Q_DEPTH];

  logic [htc_pkg::Q_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [htc_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == htc_pkg::Q_CNT_W'(htc_pkg::Q_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_item_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_en_i) begin
      wptr_d = (wptr_q == htc_pkg::Q_PTR_W'(htc_pkg::Q_DEPTH - 1)) ? '0
             : wptr_q + htc_pkg::Q_PTR_W'(1);
    end
    if (rd_en_i) begin
      rptr_d = (rptr_q == htc_pkg::Q_PTR_W'(htc_pkg::Q_DEPTH - 1)) ? '0
             : rptr_q + htc_pkg::Q_PTR_W'(1);
    end
    case ({wr_en_i, rd_en_i})
      2'b10:   cnt_d = cnt_q + htc_pkg::Q_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - htc_pkg::Q_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wptr_q] <= wr_item_i;
    end
  end

endmodule

// ----- src/htc_back.sv -----
// ----------------------------------------------------------------------------
// htc_back
// Updates the per tile column white counts and builds the result stream.
// ----------------------------------------------------------------------------
module htc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  htc_pkg::pix_item_t        q_item_i,
  output logic                      q_rd_o,
  input  logic [htc_pkg::THR_W-1:0] threshold_i,
  input  logic                      res_pop_i,
  output logic                      res_valid_o,
  output htc_pkg::result_t          res_o
);

  htc_pkg::pix_item_t u_q;
  logic               u_valid_q;
  htc_pkg::result_t   res_q, res_d;
  logic               res_valid_q;

  logic                       fwd_valid_q;
  logic [htc_pkg::TCOL_W-1:0] fwd_tc_q;
  logic [htc_pkg::CNT_W-1:0]  fwd_val_q;
  logic [htc_pkg::TILE_SLOTS-1:0] seen_q;

  logic                      advance, cnt_we;
  logic [htc_pkg::CNT_W-1:0] rd_data, base, new_cnt;

  assign advance = u_valid_q && (!res_valid_q || res_pop_i);
  assign q_rd_o  = !q_empty_i && (!u_valid_q || advance);
  assign cnt_we  = advance && u_q.counted;

  // count read issued as the pixel enters the update stage
  htc_ram #(
    .Width(htc_pkg::CNT_W),
    .Depth(htc_pkg::TILE_SLOTS)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(u_q.tcol),
    .wdata_i(new_cnt),
    .re_i   (q_rd_o),
    .raddr_i(q_item_i.tcol),
    .rdata_o(rd_data)
  );

  // last write bypasses the ram, never-written columns read as zero
  always_comb begin
    if (fwd_valid_q && fwd_tc_q == u_q.tcol) begin
      base = fwd_val_q;
    end else if (seen_q[u_q.tcol]) begin
      base = rd_data;
    end else begin
      base = '0;
    end
    new_cnt = u_q.tile_first ? htc_pkg::CNT_W'(u_q.white)
            : base + htc_pkg::CNT_W'(u_q.white);
  end

  always_comb begin
    res_d          = '0;
    res_d.is_white = u_q.white;
    if (u_q.counted && u_q.tile_last) begin
      res_d.seed_valid = htc_pkg::CMP_W'(new_cnt) >= htc_pkg::CMP_W'(threshold_i);
      res_d.tile_row   = htc_pkg::TILE_IDX_W'(u_q.trow);
      res_d.tile_col   = htc_pkg::TILE_IDX_W'(u_q.tcol);
      res_d.white_count = (new_cnt > htc_pkg::CNT_W'(htc_pkg::WCOUNT_MAX))
                        ? htc_pkg::WCOUNT_W'(htc_pkg::WCOUNT_MAX)
                        : htc_pkg::WCOUNT_W'(new_cnt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
      seen_q      <= '0;
    end else begin
      if (q_rd_o) begin
        u_valid_q <= 1'b1;
      end else if (advance) begin
        u_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      if (cnt_we) begin
        fwd_valid_q      <= 1'b1;
        seen_q[u_q.tcol] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      u_q <= q_item_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
    if (cnt_we) begin
      fwd_tc_q  <= u_q.tcol;
      fwd_val_q <= new_cnt;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- src/hsv_threshold_tile_counter.sv -----
// ----------------------------------------------------------------------------
// hsv_threshold_tile_counter
// Binarizes an HSV pixel stream and counts white pixels per 16x16 tile.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while full is low and returns one result per
// pixel, in order. A pushed pixel passes the queue, u_q and res_q; the
// front classifies and places the pixel, a two entry queue sits between it
// and the back, and the back does one read-modify-write of the 128 x 9 bit
// tile column count RAM per pixel, bypassing the last write. Columns never
// written since reset read as zero through a bank of valid flops, so there
// is no clearing pass. Registers may be written only while the block holds
// no pixel whose result is still pending.
// ----------------------------------------------------------------------------
module hsv_threshold_tile_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [htc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [htc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           push,
  output logic                           full,
  input  logic [htc_pkg::PIX_W-1:0]      hue_i,
  input  logic [htc_pkg::PIX_W-1:0]      saturation_i,
  input  logic [htc_pkg::PIX_W-1:0]      brightness_i,
  input  logic                           frame_start_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           is_white_o,
  output logic                           seed_valid_o,
  output logic [htc_pkg::TILE_IDX_W-1:0] tile_row_o,
  output logic [htc_pkg::TILE_IDX_W-1:0] tile_col_o,
  output logic [htc_pkg::WCOUNT_W-1:0]   white_count_o
);

  htc_pkg::cfg_t      cfg_q, cfg_d;
  htc_pkg::pix_item_t wr_item, rd_item;
  htc_pkg::result_t   res;
  logic               q_wr, q_rd, q_full, q_empty, res_valid;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        htc_pkg::CFG_HUE_LOW:      cfg_d.hue_low         = cfg_wdata_i[htc_pkg::PIX_W-1:0];
        htc_pkg::CFG_HUE_HIGH:     cfg_d.hue_high        = cfg_wdata_i[htc_pkg::PIX_W-1:0];
        htc_pkg::CFG_SAT_MIN:      cfg_d.sat_min         = cfg_wdata_i[htc_pkg::PIX_W-1:0];
        htc_pkg::CFG_VAL_MIN:      cfg_d.val_min         = cfg_wdata_i[htc_pkg::PIX_W-1:0];
        htc_pkg::CFG_THRESHOLD:    cfg_d.count_threshold = cfg_wdata_i[htc_pkg::THR_W-1:0];
        htc_pkg::CFG_IMAGE_WIDTH:  cfg_d.image_width     = cfg_wdata_i[htc_pkg::DIM_W-1:0];
        htc_pkg::CFG_IMAGE_HEIGHT: cfg_d.image_height    = cfg_wdata_i[htc_pkg::DIM_W-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low         <= htc_pkg::HUE_LOW_RST;
      cfg_q.hue_high        <= htc_pkg::HUE_HIGH_RST;
      cfg_q.sat_min         <= htc_pkg::SAT_MIN_RST;
      cfg_q.val_min         <= htc_pkg::VAL_MIN_RST;
      cfg_q.count_threshold <= htc_pkg::THRESHOLD_RST;
      cfg_q.image_width     <= htc_pkg::WIDTH_RST;
      cfg_q.image_height    <= htc_pkg::HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  htc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .frame_start_i(frame_start_i),
    .cfg_i        (cfg_q),
    .q_full_i     (q_full),
    .q_wr_o       (q_wr),
    .q_item_o     (wr_item)
  );

  htc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (q_wr),
    .wr_item_i(wr_item),
    .full_o   (q_full),
    .rd_en_i  (q_rd),
    .rd_item_o(rd_item),
    .empty_o  (q_empty)
  );

  htc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_item_i   (rd_item),
    .q_rd_o     (q_rd),
    .threshold_i(cfg_q.count_threshold),
    .res_pop_i  (pop),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign full          = q_full;
  assign empty         = !res_valid;
  assign is_white_o    = res.is_white;
  assign seed_valid_o  = res.seed_valid;
  assign tile_row_o    = res.tile_row;
  assign tile_col_o    = res.tile_col;
  assign white_count_o = res.white_count;

`include "hsv_threshold_tile_counter_assert.svh"

  `HTC_ASSERT_NEVER(a_queue_full_and_empty, q_full && q_empty, "pixel queue full and empty")
  `HTC_ASSERT_IMP(a_seed_meets_threshold, !empty && seed_valid_o, white_count_o >= cfg_q.count_threshold, "seed below threshold")
  `HTC_ASSERT_IMP(a_queued_pixel_reaches_output, empty && !q_empty, ##2 !empty, "queued pixel did not reach output")

endmodule

// ----- verif/hsv_threshold_tile_counter_test.sv -----
// ----------------------------------------------------------------------------
// hsv_threshold_tile_counter_test
// Self-checking bench for the hsv tile counter. Pixel requests go in through
// push/full and are classified and tile-counted in step by a local predictor.
// Every popped result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module hsv_threshold_tile_counter_test;
  import htc_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 450;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  push          = 1'b0;
  logic                  full;
  logic [PIX_W-1:0]      hue_i         = '0;
  logic [PIX_W-1:0]      saturation_i  = '0;
  logic [PIX_W-1:0]      brightness_i  = '0;
  logic                  frame_start_i = 1'b0;
  logic                  empty;
  logic                  pop           = 1'b0;
  logic                  is_white_o;
  logic                  seed_valid_o;
  logic [TILE_IDX_W-1:0] tile_row_o;
  logic [TILE_IDX_W-1:0] tile_col_o;
  logic [WCOUNT_W-1:0]   white_count_o;

  // register values as the block holds them
  cfg_t cfg_mirror = '{hue_low: HUE_LOW_RST, hue_high: HUE_HIGH_RST,
                       sat_min: SAT_MIN_RST, val_min: VAL_MIN_RST,
                       count_threshold: THRESHOLD_RST, image_width: WIDTH_RST,
                       image_height: HEIGHT_RST};

  int      tile_totals[TILE_SLOTS];
  int      col_pos;
  int      row_pos;
  result_t pending_results[$];
  bit      failed;
  int      send_idle_pct = 23;
  int      pop_idle_pct  = 23;
  int      hold_cycles;
  int      stall_cycles;

  hsv_threshold_tile_counter dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic result_t bin_and_count(logic [PIX_W-1:0] hue, logic [PIX_W-1:0] sat,
                                            logic [PIX_W-1:0] val, logic start);
    int      w;
    int      h;
    int      span_x;
    int      span_y;
    int      tc;
    int      total;
    logic    white;
    result_t res;
    w = int'(cfg_mirror.image_width);
    h = int'(cfg_mirror.image_height);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h == 0) h = 1;
    if (h > ROW_LIMIT) h = ROW_LIMIT;
    span_x = (w / TILE_SIZE) * TILE_SIZE;
    span_y = (h / TILE_SIZE) * TILE_SIZE;
    res = '0;
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    white = (hue < cfg_mirror.hue_low || hue > cfg_mirror.hue_high) &&
            sat >= cfg_mirror.sat_min && val >= cfg_mirror.val_min;
    if (col_pos < span_x && row_pos < span_y) begin
      tc = col_pos / TILE_SIZE;
      // top-left pixel restarts the column count
      if (col_pos % TILE_SIZE == 0 && row_pos % TILE_SIZE == 0) begin
        tile_totals[tc] = int'(white);
      end else begin
        tile_totals[tc] += int'(white);
      end
      if (col_pos % TILE_SIZE == TILE_SIZE - 1 && row_pos % TILE_SIZE == TILE_SIZE - 1) begin
        total = tile_totals[tc];
        res.seed_valid  = (total >= int'(cfg_mirror.count_threshold));
        res.tile_row    = TILE_IDX_W'(row_pos / TILE_SIZE);
        res.tile_col    = TILE_IDX_W'(tc);
        res.white_count = (total > WCOUNT_MAX) ? WCOUNT_W'(WCOUNT_MAX) : WCOUNT_W'(total);
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    res.is_white = white;
    return res;
  endfunction

  task automatic put_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // only called with nothing in flight
  task automatic apply_config(cfg_t c);
    put_reg(CFG_HUE_LOW, CFG_DATA_W'(c.hue_low));
    put_reg(CFG_HUE_HIGH, CFG_DATA_W'(c.hue_high));
    put_reg(CFG_SAT_MIN, CFG_DATA_W'(c.sat_min));
    put_reg(CFG_VAL_MIN, CFG_DATA_W'(c.val_min));
    put_reg(CFG_THRESHOLD, CFG_DATA_W'(c.count_threshold));
    put_reg(CFG_IMAGE_WIDTH, c.image_width);
    put_reg(CFG_IMAGE_HEIGHT, c.image_height);
    cfg_we_i   <= 1'b0;
    cfg_mirror  = c;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] hue, logic [PIX_W-1:0] sat,
                            logic [PIX_W-1:0] val, logic start);
    bit      taken;
    result_t expected;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    push          <= 1'b1;
    hue_i         <= hue;
    saturation_i  <= sat;
    brightness_i  <= val;
    frame_start_i <= start;
    // inputs only change at the rising edge, so the falling edge sees the handshake
    do begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end while (!taken);
    expected = bin_and_count(hue, sat, val, start);
    pending_results.insert(pending_results.size(), expected);
  endtask

  // density is the percentage of pixels forced white
  task automatic send_shaped_pixel(int density, logic start);
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] sat;
    logic [PIX_W-1:0] val;
    hue = PIX_W'($urandom);
    sat = PIX_W'($urandom);
    val = PIX_W'($urandom);
    if ($urandom_range(99) < density) begin
      if (cfg_mirror.hue_low != 0 && (cfg_mirror.hue_high == 8'hFF || $urandom_range(1))) begin
        hue = PIX_W'($urandom_range(int'(cfg_mirror.hue_low) - 1, 0));
      end else if (cfg_mirror.hue_high != 8'hFF) begin
        hue = PIX_W'($urandom_range(255, int'(cfg_mirror.hue_high) + 1));
      end
      sat = PIX_W'($urandom_range(255, int'(cfg_mirror.sat_min)));
      val = PIX_W'($urandom_range(255, int'(cfg_mirror.val_min)));
    end
    send_pixel(hue, sat, val, start);
  endtask

  task automatic run_frame(int density, int pixels, bit open_frame, bit noisy);
    logic start;
    for (int i = 0; i < pixels; i++) begin
      start = (i == 0 && open_frame) || (noisy && $urandom_range(999) == 0);
      send_shaped_pixel(density, start);
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic test_default_thresholds();
    send_pixel(8'd19, 8'd25, 8'd10, 1'b1);
    send_pixel(8'd20, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd120, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd121, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd121, 8'd24, 8'd255, 1'b0);
    send_pixel(8'd121, 8'd255, 8'd9, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    drain_results();
  endtask

  task automatic test_register_extremes();
    cfg_t c;
    c = cfg_mirror;
    // band covers every hue: nothing can be white
    c.hue_low = 8'd0;
    c.hue_high = 8'd255;
    c.sat_min = 8'd0;
    c.val_min = 8'd0;
    apply_config(c);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd128, 8'd170, 8'd85, 1'b0);
    drain_results();
    // inverted band: every hue is outside
    c.hue_low = 8'd255;
    c.hue_high = 8'd0;
    apply_config(c);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    drain_results();
    c.sat_min = 8'd255;
    c.val_min = 8'd255;
    apply_config(c);
    send_pixel(8'd200, 8'd254, 8'd255, 1'b0);
    send_pixel(8'd200, 8'd255, 8'd254, 1'b0);
    send_pixel(8'd200, 8'd255, 8'd255, 1'b0);
    drain_results();
  endtask

  task automatic test_geometry_extremes();
    cfg_t c;
    c = cfg_mirror;
    c.sat_min = 8'd0;
    c.val_min = 8'd0;
    c.image_width = '0;
    c.image_height = '0;
    apply_config(c);
    for (int i = 0; i < 3; i++) send_shaped_pixel(50, i == 0);
    drain_results();
    c.image_width = 12'hFFF;
    c.image_height = 12'hFFF;
    apply_config(c);
    for (int i = 0; i < 3; i++) send_shaped_pixel(50, 1'b0);
    drain_results();
    c.image_width = CFG_DATA_W'(MAX_WIDTH);
    c.image_height = 12'd1;
    apply_config(c);
    for (int i = 0; i < 2; i++) send_shaped_pixel(50, i == 0);
    drain_results();
  endtask

  task automatic test_backpressure();
    cfg_t c;
    c = '{hue_low: 8'd20, hue_high: 8'd120, sat_min: 8'd25, val_min: 8'd10,
          count_threshold: 9'd256, image_width: 12'd16, image_height: 12'd16};
    apply_config(c);
    // receiver stalls while the whole tile is offered, so full must rise
    hold_cycles = HOLD_CYCLES;
    run_frame(100, 256, 1'b1, 1'b0);
    drain_results();
    c.count_threshold = '0;
    apply_config(c);
    run_frame(0, 256, 1'b1, 1'b0);
    drain_results();
  endtask

  task automatic test_no_idle();
    cfg_t c;
    c = '{hue_low: 8'd64, hue_high: 8'd192, sat_min: 8'd40, val_min: 8'd40,
          count_threshold: 9'd128, image_width: 12'd16, image_height: 12'd16};
    apply_config(c);
    send_idle_pct = 0;
    pop_idle_pct = 0;
    run_frame(50, 256, 1'b1, 1'b0);
    drain_results();
    send_idle_pct = 23;
    pop_idle_pct = 23;
  endtask

  task automatic test_random_frames();
    cfg_t c;
    int   sent;
    int   density;
    int   thr;
    int   w;
    int   h;
    int   pixels;
    bit   open_frame;
    bit   last_whole;
    sent = 0;
    last_whole = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      case ($urandom_range(4))
        0: density = 0;
        1: density = 30;
        2: density = 70;
        3: density = 95;
        default: density = 100;
      endcase
      case ($urandom_range(7))
        0: thr = 0;
        1: thr = 256;
        2: thr = int'($urandom_range(511, 257));
        default: begin
          thr = density * 256 / 100 + int'($urandom_range(48)) - 24;
          if (thr < 0) thr = 0;
          if (thr > 256) thr = 256;
        end
      endcase
      w = ($urandom_range(5) == 0) ? int'($urandom_range(15, 1)) : int'($urandom_range(40, 16));
      h = ($urandom_range(7) == 0 && w <= 24) ? int'($urandom_range(40, 32))
                                               : int'($urandom_range(20, 16));
      c.hue_low = PIX_W'($urandom_range(255, 1));
      c.hue_high = PIX_W'($urandom);
      c.sat_min = PIX_W'($urandom);
      c.val_min = PIX_W'($urandom);
      c.count_threshold = THR_W'(thr);
      c.image_width = DIM_W'(w);
      c.image_height = DIM_W'(h);
      apply_config(c);
      pixels = w * h;
      // after a cut frame, sometimes carry on from the old position under the new geometry
      open_frame = last_whole || $urandom_range(1);
      last_whole = ($urandom_range(4) != 0);
      if (!last_whole) pixels = int'($urandom_range(pixels, 1));
      if (pixels > RANDOM_ITEMS - sent) pixels = RANDOM_ITEMS - sent;
      run_frame(density, pixels, open_frame, $urandom_range(3) == 0);
      sent += pixels;
    end
    drain_results();
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      pop <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  always @(negedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result popped with no request outstanding");
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("is_white", int'(want.is_white), int'(is_white_o));
        check_field("seed_valid", int'(want.seed_valid), int'(seed_valid_o));
        check_field("tile_row", int'(want.tile_row), int'(tile_row_o));
        check_field("tile_col", int'(want.tile_col), int'(tile_col_o));
        check_field("white_count", int'(want.white_count), int'(white_count_o));
      end
    end
  end

  always @(negedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_thresholds();
    test_register_extremes();
    test_geometry_extremes();
    test_backpressure();
    test_no_idle();
    test_random_frames();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (!failed && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
